>>> rtl/fue_pkg.sv
// shared types, character constants and the hex digit function of the form url encoder
// no dependencies
`default_nettype none

package fue_pkg;

   // depth of the run queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // ascii codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_LF      = 8'h0a;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_D = 8'h44;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_TILDE   = 8'h7e;
   localparam logic [7:0] CHAR_STAR    = 8'h2a;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;

   // what the back end has to emit for one input byte
   typedef enum logic [1:0] {
      RUN_LITERAL,   // one character, carried in value
      RUN_ESCAPE,    // percent and two hex digits of value
      RUN_CRLF       // the six characters %0D%0A
   } run_kind_type;

   typedef struct packed {
      run_kind_type kind;
      logic [7:0]   value;
      logic         last;
   } run_entry_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_LAST_ESCAPE = 3'd2;
   localparam step_type STEP_LAST_CRLF   = 3'd5;

   // upper-case hex digit of one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_UPPER_A + wide - 8'd10;
   endfunction

endpackage

`default_nettype wire

>>> rtl/fue_if.sv
// valid/ready channel interfaces for the byte input and the character output
// depends on nothing
`default_nettype none

interface fue_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface fue_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_run_end;
   logic       out_string_end;

   modport source (output valid, output out_char, output out_run_end,
                   output out_string_end, input ready);
   modport sink   (input valid, input out_char, input out_run_end,
                   input out_string_end, output ready);
endinterface

`default_nettype wire

>>> rtl/form_url_encoder.sv
// form url encoder top level: front end, run queue and back end
// the first character of a byte is registered in the run queue, then in the output register
// throughput: one output character per cycle from the back end sequencer when not stalled,
// so a byte gives 1 character (pass-through or space), 3 (escape) or 6 (lf not after cr)
// reset: synchronous, clears the cr flag, the queue and the output valid bit
// depends on fue_pkg, fue_if, fue_front, fue_queue and fue_back
`default_nettype none

module form_url_encoder #(
   parameter int unsigned QUEUE_DEPTH = fue_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   fue_req_if.sink   req_chan,
   fue_rsp_if.source rsp_chan
);

   logic                   push_valid;
   logic                   push_ready;
   fue_pkg::run_entry_type push_entry;
   logic                   pop_valid;
   logic                   pop_ready;
   fue_pkg::run_entry_type pop_entry;

   // classify incoming bytes
   fue_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // decouple front and back
   fue_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // emit characters
   fue_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/fue_front.sv
// front end: accepts input bytes, classifies them and tracks the cr flag
// depends on fue_pkg and fue_req_if
`default_nettype none

module fue_front (
   input  logic                   clock,
   input  logic                   reset,
   fue_req_if.sink                req_chan,
   output logic                   push_valid,
   output fue_pkg::run_entry_type push_entry,
   input  logic                   push_ready
);

   logic prev_cr_ff;
   logic prev_cr_in;
   logic accept;

   // unreserved characters that pass through
   function automatic logic byte_passes(input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (b >= fue_pkg::CHAR_ZERO && b <= fue_pkg::CHAR_NINE) begin
         hit = 1'b1;
      end
      if (b >= fue_pkg::CHAR_UPPER_A && b <= fue_pkg::CHAR_UPPER_Z) begin
         hit = 1'b1;
      end
      if (b >= fue_pkg::CHAR_LOWER_A && b <= fue_pkg::CHAR_LOWER_Z) begin
         hit = 1'b1;
      end
      if (b == fue_pkg::CHAR_DASH || b == fue_pkg::CHAR_UNDER || b == fue_pkg::CHAR_DOT ||
          b == fue_pkg::CHAR_BANG || b == fue_pkg::CHAR_TILDE || b == fue_pkg::CHAR_STAR ||
          b == fue_pkg::CHAR_QUOTE || b == fue_pkg::CHAR_LPAREN ||
          b == fue_pkg::CHAR_RPAREN) begin
         hit = 1'b1;
      end
      return hit;
   endfunction

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   // classify the byte into a run
   always_comb begin
      push_entry.last  = req_chan.in_last;
      push_entry.value = req_chan.in_byte;
      push_entry.kind  = fue_pkg::RUN_ESCAPE;
      if (byte_passes(req_chan.in_byte)) begin
         push_entry.kind = fue_pkg::RUN_LITERAL;
      end else if (req_chan.in_byte == fue_pkg::CHAR_SPACE) begin
         push_entry.kind  = fue_pkg::RUN_LITERAL;
         push_entry.value = fue_pkg::CHAR_PLUS;
      end else if (req_chan.in_byte == fue_pkg::CHAR_LF && !prev_cr_ff) begin
         push_entry.kind = fue_pkg::RUN_CRLF;
      end
   end

   // cr flag: set after a cr that does not end the string
   always_comb begin
      prev_cr_in = prev_cr_ff;
      if (accept) begin
         prev_cr_in = (req_chan.in_byte == fue_pkg::CHAR_CR) && !req_chan.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cr_ff <= 1'b0;
      end else begin
         prev_cr_ff <= prev_cr_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fue_queue.sv
// run queue between front and back end, a small circular buffer
// depends on fue_pkg
`default_nettype none

module fue_queue #(
   parameter int unsigned DEPTH = fue_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  fue_pkg::run_entry_type push_entry,
   output logic                   push_ready,
   output logic                   pop_valid,
   output fue_pkg::run_entry_type pop_entry,
   input  logic                   pop_ready
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   fue_pkg::run_entry_type entry_mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fue_back.sv
// back end: steps through each run one character a beat into the output register
// depends on fue_pkg and fue_rsp_if
`default_nettype none

module fue_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  fue_pkg::run_entry_type pop_entry,
   output logic                   pop_ready,
   fue_rsp_if.source              rsp_chan
);

   fue_pkg::step_type step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        char_ff, char_in;
   logic              run_end_ff, run_end_in;
   logic              string_end_ff, string_end_in;
   logic              advance;
   logic [7:0]        cur_char;
   logic              cur_end;

   assign advance = pop_valid && (!rsp_valid_ff || rsp_chan.ready);

   // character at the current step of the run
   always_comb begin
      cur_char = pop_entry.value;
      cur_end  = 1'b1;
      case (pop_entry.kind)
         fue_pkg::RUN_LITERAL: begin
            cur_char = pop_entry.value;
            cur_end  = 1'b1;
         end
         fue_pkg::RUN_ESCAPE: begin
            cur_end = (step_ff == fue_pkg::STEP_LAST_ESCAPE);
            case (step_ff)
               3'd0:    cur_char = fue_pkg::CHAR_PERCENT;
               3'd1:    cur_char = fue_pkg::hex_digit(pop_entry.value[7:4]);
               default: cur_char = fue_pkg::hex_digit(pop_entry.value[3:0]);
            endcase
         end
         fue_pkg::RUN_CRLF: begin
            cur_end = (step_ff == fue_pkg::STEP_LAST_CRLF);
            case (step_ff)
               3'd0, 3'd3: cur_char = fue_pkg::CHAR_PERCENT;
               3'd1, 3'd4: cur_char = fue_pkg::CHAR_ZERO;
               3'd2:       cur_char = fue_pkg::CHAR_UPPER_D;
               default:    cur_char = fue_pkg::CHAR_UPPER_A;
            endcase
         end
         default: begin
            cur_char = pop_entry.value;
            cur_end  = 1'b1;
         end
      endcase
   end

   assign pop_ready = advance && cur_end;

   // step counter and output register
   always_comb begin
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      char_in       = char_ff;
      run_end_in    = run_end_ff;
      string_end_in = string_end_ff;
      if (advance) begin
         rsp_valid_in  = 1'b1;
         char_in       = cur_char;
         run_end_in    = cur_end;
         string_end_in = cur_end && pop_entry.last;
         step_in       = cur_end ? '0 : step_ff + 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      run_end_ff    <= run_end_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_char       = char_ff;
   assign rsp_chan.out_run_end    = run_end_ff;
   assign rsp_chan.out_string_end = string_end_ff;

endmodule

`default_nettype wire

>>> rtl/fue_checker.sv
// port-level checks of the form url encoder output channel, bound to the top level
// depends on form_url_encoder and fue_pkg
`default_nettype none

module fue_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char,
   input logic       rsp_run_end,
   input logic       rsp_string_end
);

   // a stalled beat stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("output beat dropped while stalled");

   // a stalled beat keeps its character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_char))
      else $error("output character changed while stalled");

   // string end only on the last character of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

   // a percent sign always opens an escape and never ends a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char == fue_pkg::CHAR_PERCENT |-> !rsp_run_end)
      else $error("run ends on a percent sign");

endmodule

bind form_url_encoder fue_checker u_fue_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_char       (rsp_chan.out_char),
   .rsp_run_end    (rsp_chan.out_run_end),
   .rsp_string_end (rsp_chan.out_string_end)
);

`default_nettype wire
